// ===== src/ita_pkg.sv =====
// shared types and constants for the integer to ascii formatter
// no dependencies
`timescale 1ns / 1ps

package ita_pkg;

    localparam logic [1:0] MODE_SINT   = 2'd0;
    localparam logic [1:0] MODE_UINT   = 2'd1;
    localparam logic [1:0] MODE_SSHORT = 2'd2;
    localparam logic [1:0] MODE_USHORT = 2'd3;

    localparam logic [1:0] PAD_NONE  = 2'd0;
    localparam logic [1:0] PAD_SPACE = 2'd1;
    localparam logic [1:0] PAD_ZERO  = 2'd2;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_LA    = 8'h61;

    localparam int BCD_DIGITS     = 10;
    localparam int BITS_PER_STAGE = 4;
    localparam int BCD_STAGES     = 32 / BITS_PER_STAGE;

    typedef struct packed {
        logic [31:0] bin;
        logic [39:0] bcd;
        logic        neg;
        logic        hex;
        logic        upper;
        logic [6:0]  fw;
        logic [4:0]  prec;
        logic [1:0]  pad;
        logic [3:0]  sig;
    } item_t;

    function automatic logic [31:0] pow10(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd1:    r = 32'd10;
            4'd2:    r = 32'd100;
            4'd3:    r = 32'd1000;
            4'd4:    r = 32'd10000;
            4'd5:    r = 32'd100000;
            4'd6:    r = 32'd1000000;
            4'd7:    r = 32'd10000000;
            4'd8:    r = 32'd100000000;
            4'd9:    r = 32'd1000000000;
            default: r = 32'd1;
        endcase
        return r;
    endfunction

endpackage

// ===== src/ita_decode.sv =====
// input stage: sign and magnitude, significant digit count
// depends on ita_pkg
`timescale 1ns / 1ps

module ita_decode import ita_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       value,
    input  logic [1:0]        mode,
    input  logic              base_hex,
    input  logic              upper_case,
    input  logic signed [6:0] field_width,
    input  logic [4:0]        precision,
    input  logic [1:0]        pad_mode,
    output logic              out_valid,
    input  logic              out_ready,
    output item_t             out_item
);

    logic  valid_reg;
    item_t item_reg, item_next;
    logic [31:0] mag;
    logic        neg;
    logic [3:0]  sig;

    always_comb begin
        neg = 1'b0;
        mag = value;
        case (mode)
            MODE_SINT: begin
                neg = value[31];
                mag = value[31] ? (32'd0 - value) : value;
            end
            MODE_UINT: mag = value;
            MODE_SSHORT: begin
                neg = value[15];
                mag = {16'd0, value[15] ? (16'd0 - value[15:0]) : value[15:0]};
            end
            default: mag = {16'd0, value[15:0]};
        endcase
        sig = 4'd1;
        if (base_hex) begin
            for (int i = 1; i < 8; i++) begin
                if (mag[4*i +: 4] != 4'd0) sig = 4'(i + 1);
            end
        end else begin
            for (int k = 1; k < 10; k++) begin
                if (mag >= pow10(4'(k))) sig = 4'(k + 1);
            end
        end
        item_next.bin   = mag;
        item_next.bcd   = 40'd0;
        item_next.neg   = neg;
        item_next.hex   = base_hex;
        item_next.upper = upper_case;
        item_next.fw    = field_width;
        item_next.prec  = precision;
        item_next.pad   = pad_mode;
        item_next.sig   = sig;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== src/ita_bcd_stage.sv =====
// one double-dabble stage, four binary bits into the bcd register
// depends on ita_pkg
`timescale 1ns / 1ps

module ita_bcd_stage import ita_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    logic  valid_reg;
    item_t item_reg, item_next;
    logic [39:0] bcd;
    logic [31:0] bin;

    always_comb begin
        bcd = in_item.bcd;
        bin = in_item.bin;
        if (!in_item.hex) begin
            for (int s = 0; s < BITS_PER_STAGE; s++) begin
                for (int d = 0; d < BCD_DIGITS; d++) begin
                    if (bcd[4*d +: 4] >= 4'd5) bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
                end
                bcd = {bcd[38:0], bin[31]};
                bin = {bin[30:0], 1'b0};
            end
        end
        item_next     = in_item;
        item_next.bcd = bcd;
        item_next.bin = bin;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== src/ita_serializer.sv =====
// emits the formatted characters of one item, one per cycle while out_ready is high
// depends on ita_pkg
`timescale 1ns / 1ps

module ita_serializer import ita_pkg::*; #(
    parameter int MAX_DIGITS = 28,
    parameter int MAX_WIDTH  = 63
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  item_t      in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       out_last
);

    localparam int PW = $clog2(MAX_WIDTH + MAX_DIGITS + 2);

    logic          valid_reg;
    logic [39:0]   dig_reg;
    logic          upper_reg, neg_reg, zero_pad_reg;
    logic [PW-1:0] lead_reg, len_reg, total_reg, pos_reg;

    logic [7:0]    wm8;
    logic [PW-1:0] wmag, precc, nd, len, gap, lead, trail;
    logic          left, use_pad;
    logic [PW-1:0] rel, idx;
    logic [3:0]    d;
    logic [39:0]   dshift;

    always_comb begin
        left  = in_item.fw[6];
        wm8   = left ? (8'd128 - {1'b0, in_item.fw}) : {1'b0, in_item.fw};
        wmag  = (wm8 > 8'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : PW'(wm8);
        precc = (in_item.prec > 5'(MAX_DIGITS)) ? PW'(MAX_DIGITS) : PW'(in_item.prec);
        nd    = (PW'(in_item.sig) > precc) ? PW'(in_item.sig) : precc;
        if (nd > PW'(MAX_DIGITS)) nd = PW'(MAX_DIGITS);
        len   = nd + PW'(in_item.neg);
        gap   = (wmag > len) ? (wmag - len) : '0;
        use_pad = !left && (in_item.pad == PAD_SPACE || in_item.pad == PAD_ZERO);
        lead  = use_pad ? gap : '0;
        trail = left ? gap : '0;
    end

    always_comb begin
        rel    = pos_reg - lead_reg;
        idx    = len_reg - PW'(1) - rel;
        dshift = dig_reg >> {idx[3:0], 2'b00};
        d      = (idx < PW'(BCD_DIGITS)) ? dshift[3:0] : 4'd0;
        if (pos_reg < lead_reg) begin
            out_char = zero_pad_reg ? CHAR_ZERO : CHAR_SPACE;
        end else if (rel < len_reg) begin
            if (neg_reg && rel == '0) out_char = CHAR_MINUS;
            else if (d < 4'd10) out_char = CHAR_ZERO + {4'd0, d};
            else out_char = (upper_reg ? CHAR_UA : CHAR_LA) + {4'd0, d - 4'd10};
        end else begin
            out_char = CHAR_SPACE;
        end
    end

    assign out_valid = valid_reg;
    assign out_last  = (pos_reg == total_reg - PW'(1));
    assign in_ready  = !valid_reg || (out_ready && out_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
            pos_reg   <= '0;
        end else if (out_ready) begin
            pos_reg <= pos_reg + PW'(1);
        end
        if (in_ready && in_valid) begin
            dig_reg      <= in_item.hex ? {8'd0, in_item.bin} : in_item.bcd;
            upper_reg    <= in_item.upper;
            neg_reg      <= in_item.neg;
            zero_pad_reg <= (in_item.pad == PAD_ZERO);
            lead_reg     <= lead;
            len_reg      <= len;
            total_reg    <= lead + len + trail;
        end
    end

endmodule

// ===== src/integer_to_ascii_formatter.sv =====
// first character: a request passes the decode register and the eight bcd stages, and its
//   first character is presented once the request has loaded the character stage register
// throughput: one character per cycle while m_ready is high; a request holds the character
//   stage for its digit count plus sign, plus padding up to the field width when left-justified
//   or when a space or zero pad is chosen; the next request loads as the last character is taken
// reset: synchronous active-low aresetn clears all valid flags and the position count
`timescale 1ns / 1ps

module integer_to_ascii_formatter import ita_pkg::*; #(
    parameter int MAX_DIGITS = 28,
    parameter int MAX_WIDTH  = 63
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [31:0]       s_value,
    input  logic [1:0]        s_mode,
    input  logic              s_base_hex,
    input  logic              s_upper_case,
    input  logic signed [6:0] s_field_width,
    input  logic [4:0]        s_precision,
    input  logic [1:0]        s_pad_mode,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_char,
    output logic              m_last_char
);

    // stage links: index 0 is the decode output, BCD_STAGES the last bcd stage
    logic  link_valid [BCD_STAGES+1];
    logic  link_ready [BCD_STAGES+1];
    item_t link_item  [BCD_STAGES+1];

    // decode: sign, magnitude and significant digit count
    ita_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .value       (s_value),
        .mode        (s_mode),
        .base_hex    (s_base_hex),
        .upper_case  (s_upper_case),
        .field_width (s_field_width),
        .precision   (s_precision),
        .pad_mode    (s_pad_mode),
        .out_valid   (link_valid[0]),
        .out_ready   (link_ready[0]),
        .out_item    (link_item[0])
    );

    // binary to bcd, four shift steps per stage; hex items pass untouched
    for (genvar g = 0; g < BCD_STAGES; g++) begin : g_bcd
        ita_bcd_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[g]),
            .in_ready  (link_ready[g]),
            .in_item   (link_item[g]),
            .out_valid (link_valid[g+1]),
            .out_ready (link_ready[g+1]),
            .out_item  (link_item[g+1])
        );
    end

    // character stage: padding, sign, digits, trailing spaces
    ita_serializer #(
        .MAX_DIGITS (MAX_DIGITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (link_valid[BCD_STAGES]),
        .in_ready  (link_ready[BCD_STAGES]),
        .in_item   (link_item[BCD_STAGES]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_char  (m_out_char),
        .out_last  (m_last_char)
    );

    // a run of characters has no gaps once started
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_char |=> m_valid)
        else $error("character run broken");

    // a stalled character holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_char) && $stable(m_last_char))
        else $error("stalled character changed");

    // every character is printable
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_char >= CHAR_SPACE)
        else $error("non-printable character");

endmodule
